// ----- rtl/cro_pkg.sv -----
// shared types and constants for the cosine range oscillator
package cro_pkg;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COMPONENT = 3'd3;

    localparam logic [31:0] PERIOD_RESET = 32'd1000;
    localparam logic [31:0] LOW_RESET    = 32'd0;
    localparam logic [31:0] HIGH_RESET   = 32'd65536;

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:    r = 32'h20000000;
                5'd1:    r = 32'h12E4051E;
                5'd2:    r = 32'h09FB385B;
                5'd3:    r = 32'h051111D4;
                5'd4:    r = 32'h028B0D43;
                5'd5:    r = 32'h0145D7E1;
                5'd6:    r = 32'h00A2F61E;
                5'd7:    r = 32'h00517C55;
                5'd8:    r = 32'h0028BE53;
                5'd9:    r = 32'h00145F2F;
                5'd10:   r = 32'h000A2F98;
                5'd11:   r = 32'h000517CC;
                5'd12:   r = 32'h00028BE6;
                5'd13:   r = 32'h000145F3;
                5'd14:   r = 32'h0000A2FA;
                5'd15:   r = 32'h0000517D;
                5'd16:   r = 32'h000028BE;
                5'd17:   r = 32'h0000145F;
                5'd18:   r = 32'h00000A30;
                5'd19:   r = 32'h00000518;
                5'd20:   r = 32'h0000028C;
                5'd21:   r = 32'h00000146;
                5'd22:   r = 32'h000000A3;
                5'd23:   r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    // phase word handed from the front part to the back part
    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] low;
        logic [31:0] high;
        logic [1:0]  comp;
    } cro_job_t;

endpackage

// ----- rtl/cro_front.sv -----
// front part: modulo and phase division as a restoring divider pipeline
module cro_front #(
    parameter int TIME_BITS  = 48,
    parameter int PHASE_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TIME_BITS-1:0] in_time,
    input  logic [31:0]       period,
    input  logic [31:0]       low,
    input  logic [31:0]       high,
    input  logic [1:0]        comp,
    output logic              out_valid,
    input  logic              out_ready,
    output cro_pkg::cro_job_t out_job
);
    import cro_pkg::*;

    // stages 0..TIME_BITS-1 reduce time mod period, the rest make phase bits
    localparam int NST = TIME_BITS + PHASE_BITS;

    logic              vld_reg   [NST];
    logic [32:0]       rem_reg   [NST];
    logic [TIME_BITS-1:0] t_reg  [NST];
    logic [PHASE_BITS-1:0] q_reg [NST];
    logic [31:0]       per_reg   [NST];
    logic [31:0]       lo_reg    [NST];
    logic [31:0]       hi_reg    [NST];
    logic [1:0]        cp_reg    [NST];

    logic              adv;
    logic [31:0]       per_in;

    assign adv      = out_ready || !vld_reg[NST-1];
    assign in_ready = adv;
    assign per_in   = (period == 32'd0) ? 32'd1 : period;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [32:0] tr;
            logic [32:0] pr;
            tr = {32'd0, in_time[TIME_BITS-1]};
            pr = {1'b0, per_in};
            rem_reg[0] <= (tr >= pr) ? tr - pr : tr;
            t_reg[0]   <= in_time << 1;
            q_reg[0]   <= '0;
            per_reg[0] <= per_in;
            lo_reg[0]  <= low;
            hi_reg[0]  <= high;
            cp_reg[0]  <= comp;
            for (int s = 1; s < NST; s++)
            begin
                logic [32:0] tt;
                logic [32:0] pp;
                logic        ge;
                pp = {1'b0, per_reg[s-1]};
                if (s < TIME_BITS)
                begin
                    tt = {rem_reg[s-1][31:0], t_reg[s-1][TIME_BITS-1]};
                end
                else
                begin
                    tt = {rem_reg[s-1][31:0], 1'b0};
                end
                ge = (tt >= pp);
                rem_reg[s] <= ge ? tt - pp : tt;
                t_reg[s]   <= t_reg[s-1] << 1;
                q_reg[s]   <= (s >= TIME_BITS) ? {q_reg[s-1][PHASE_BITS-2:0], ge}
                                               : q_reg[s-1];
                per_reg[s] <= per_reg[s-1];
                lo_reg[s]  <= lo_reg[s-1];
                hi_reg[s]  <= hi_reg[s-1];
                cp_reg[s]  <= cp_reg[s-1];
            end
        end
    end

    assign out_valid     = vld_reg[NST-1];
    assign out_job.angle = {q_reg[NST-1], {(32-PHASE_BITS){1'b0}}};
    assign out_job.low   = lo_reg[NST-1];
    assign out_job.high  = hi_reg[NST-1];
    assign out_job.comp  = cp_reg[NST-1];

endmodule

// ----- rtl/cro_queue.sv -----
// short word queue between front and back parts
module cro_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cro_pkg::cro_job_t in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output cro_pkg::cro_job_t out_job
);
    import cro_pkg::*;

    localparam int AW = $clog2(DEPTH);

    cro_job_t        mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   rp_reg;
    logic [AW:0]     cnt_reg;
    logic            wr;
    logic            rd;

    assign in_ready  = (cnt_reg != DEPTH[AW:0]);
    assign out_valid = (cnt_reg != '0);
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;
    assign out_job   = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= in_job;
        end
    end

endmodule

// ----- rtl/cro_back.sv -----
// back part: cordic pipeline, scaling multiply and saturation
module cro_back #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cro_pkg::cro_job_t in_job,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [31:0]       out_value,
    output logic [1:0]        out_comp
);
    import cro_pkg::*;

    // stage 0 folds quadrants, CORDIC_STAGES rotations, then clamp/diff,
    // multiply, round/add, saturate
    localparam int NC  = CORDIC_STAGES + 1;
    localparam int NST = NC + 4;

    logic                vld_reg [NST];
    logic signed [33:0]  x_reg   [NC];
    logic signed [33:0]  y_reg   [NC];
    logic signed [33:0]  z_reg   [NC];
    logic                neg_reg [NC];
    logic [31:0]         lo_reg  [NST];
    logic [31:0]         hi_reg  [NC];
    logic [1:0]          cp_reg  [NST];

    logic [31:0]         w_reg;
    logic [32:0]         mag_reg;
    logic                dn_reg;
    logic                dn2_reg;
    logic [63:0]         prod_reg;
    logic signed [34:0]  sum_reg;
    logic [31:0]         val_reg;
    logic                adv;

    assign adv      = out_ready || !vld_reg[NST-1];
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < NST; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic        ng;
            logic [31:0] a;
            logic signed [33:0] xc;
            logic signed [33:0] cs;
            logic signed [33:0] d;
            ng = (in_job.angle[31:30] == 2'b01) || (in_job.angle[31:30] == 2'b10);
            a  = ng ? in_job.angle - 32'h80000000 : in_job.angle;
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= 34'(signed'(a));
            neg_reg[0] <= ng;
            lo_reg[0]  <= in_job.low;
            hi_reg[0]  <= in_job.high;
            cp_reg[0]  <= in_job.comp;
            for (int s = 1; s < NC; s++)
            begin
                logic signed [33:0] dx;
                logic signed [33:0] dy;
                logic signed [33:0] at;
                dx = y_reg[s-1] >>> (s-1);
                dy = x_reg[s-1] >>> (s-1);
                at = 34'(atan_turns(5'(s-1)));
                if (!z_reg[s-1][33])
                begin
                    x_reg[s] <= x_reg[s-1] - dx;
                    y_reg[s] <= y_reg[s-1] + dy;
                    z_reg[s] <= z_reg[s-1] - at;
                end
                else
                begin
                    x_reg[s] <= x_reg[s-1] + dx;
                    y_reg[s] <= y_reg[s-1] - dy;
                    z_reg[s] <= z_reg[s-1] + at;
                end
                neg_reg[s] <= neg_reg[s-1];
                hi_reg[s]  <= hi_reg[s-1];
            end
            for (int s = 1; s < NST; s++)
            begin
                lo_reg[s] <= lo_reg[s-1];
                cp_reg[s] <= cp_reg[s-1];
            end
            // clamp, sign fold, weight and bound difference
            xc = x_reg[NC-1];
            if (xc > ONE_Q30)
            begin
                xc = ONE_Q30;
            end
            if (xc < -ONE_Q30)
            begin
                xc = -ONE_Q30;
            end
            cs = neg_reg[NC-1] ? -xc : xc;
            w_reg   <= 32'(cs + ONE_Q30);
            d       = 34'(signed'(hi_reg[NC-1])) - 34'(signed'(lo_reg[NC-1]));
            dn_reg  <= d[33];
            mag_reg <= 33'(d[33] ? -d : d);
            // multiply
            prod_reg <= 64'({31'd0, mag_reg} * {32'd0, w_reg});
            dn2_reg  <= dn_reg;
            // round and add
            begin
                logic [63:0] off;
                off = (prod_reg + 64'h40000000) >> 31;
                sum_reg <= dn2_reg ? 35'(signed'(lo_reg[NC+1])) - 35'(off)
                                   : 35'(signed'(lo_reg[NC+1])) + 35'(off);
            end
            // saturate
            if (sum_reg > 35'sd2147483647)
            begin
                val_reg <= 32'h7FFFFFFF;
            end
            else if (sum_reg < -35'sd2147483648)
            begin
                val_reg <= 32'h80000000;
            end
            else
            begin
                val_reg <= sum_reg[31:0];
            end
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_value = val_reg;
    assign out_comp  = cp_reg[NST-1];

endmodule

// ----- rtl/cosine_range_oscillator.sv -----
// top level of the cosine range oscillator
// usage
//   s_axis carries one time count word per beat; m_axis returns one result
//   word per accepted input, in order
//   the front part reduces the time modulo the period and divides out the
//   phase, one quotient bit per stage
//   a four-word queue parts it from the back part, which runs the cordic
//   (one stage per rotation plus a quadrant fold), a clamp, the 33x32
//   scaling multiply, rounding and saturation
//   throughput is one word per cycle while m_axis_tready stays high,
//   set by the pipelined divider and cordic
//   when m_axis_tready is low the back pipeline holds, the queue fills and
//   then the front pipeline holds and s_axis_tready falls
//   reset clears all valid flags and loads period 1000, bounds 0 and 1.0,
//   component 0; a zero period acts as a period of one
//   configuration writes are taken on cfg_we at any time but are meant
//   for an idle block; indexes above three are ignored
module cosine_range_oscillator #(
    parameter int TIME_BITS     = 48,
    parameter int CORDIC_STAGES = 16,
    parameter int PHASE_BITS    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cro_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cro_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // total_time
    input  logic [((TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // osc_value
    output logic [31:0]                   m_axis_tdata,
    // component_index
    output logic [1:0]                    m_axis_tuser
);
    import cro_pkg::*;

    logic [31:0] period_reg;
    logic [31:0] low_reg;
    logic [31:0] high_reg;
    logic [1:0]  comp_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            low_reg    <= LOW_RESET;
            high_reg   <= HIGH_RESET;
            comp_reg   <= 2'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PERIOD:    period_reg <= cfg_data;
                REG_LOW:       low_reg    <= cfg_data;
                REG_HIGH:      high_reg   <= cfg_data;
                REG_COMPONENT: comp_reg   <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    logic     f_valid;
    logic     f_ready;
    cro_job_t f_job;
    logic     q_valid;
    logic     q_ready;
    cro_job_t q_job;

    // front: modulo and phase divider
    cro_front #(
        .TIME_BITS  (TIME_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_time   (s_axis_tdata[TIME_BITS-1:0]),
        .period    (period_reg),
        .low       (low_reg),
        .high      (high_reg),
        .comp      (comp_reg),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_job   (f_job)
    );

    // decoupling queue
    cro_queue #(
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_job    (f_job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    // back: cordic and scaling
    cro_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_job    (q_job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (m_axis_tdata),
        .out_comp  (m_axis_tuser)
    );

endmodule

// ----- rtl/cro_checker.sv -----
// port-level checks for the cosine range oscillator, with its bind
module cro_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    // a stalled result word holds its value
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // nothing comes out in the cycle after reset
    a_rst: assert property (@(posedge clk) $rose(rst_n) |-> !m_axis_tvalid)
        else $error("result right after reset");

    // input side accepts again once the receiver drains
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");
endmodule

bind cosine_range_oscillator cro_checker u_cro_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
